@@ sv/jsu_pkg.sv @@
// Shared types and codes for the JSON string unescaper.
// No dependencies; imported by every module of the block.
package jsu_pkg;

   // Result word kinds
   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // Error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_MISSING_Q = 3'd1;
   localparam logic [2:0] ERR_BAD_ESC   = 3'd2;
   localparam logic [2:0] ERR_BAD_HEX   = 3'd3;
   localparam logic [2:0] ERR_BAD_SURR  = 3'd4;
   localparam logic [2:0] ERR_CTRL_CHAR = 3'd5;

   localparam int QUEUE_DEPTH_DEF = 4;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       restart;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic [2:0] error_code;
      logic       last;
   } rsp_payload_type;

   // One decoded input byte: 1 to 4 result words.
   typedef struct packed {
      logic [1:0]      last_idx;
      logic [1:0]      kind;
      logic [2:0]      error_code;
      logic [3:0][7:0] bytes;
   } job_type;

endpackage

@@ sv/jsu_chan_if.sv @@
// Valid/ready channel carrying one payload word per handshake.
// Payload type is a parameter; used by the top level ports.
interface jsu_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ sv/jsu_front.sv @@
// Front end: accepts input words, runs the unescape state machine and
// produces one job per input that yields results. Depends on jsu_pkg and jsu_chan_if.
module jsu_front (
   input  logic             clock,
   input  logic             reset,
   jsu_chan_if.sink         req_ch,
   input  logic             q_full,
   output logic             push,
   output jsu_pkg::job_type push_job
);
   import jsu_pkg::*;

   localparam logic [2:0] M_NORMAL = 3'd0;
   localparam logic [2:0] M_ESC    = 3'd1;
   localparam logic [2:0] M_HEX1   = 3'd2;
   localparam logic [2:0] M_EXP_BS = 3'd3;
   localparam logic [2:0] M_EXP_U  = 3'd4;
   localparam logic [2:0] M_HEX2   = 3'd5;
   localparam logic [2:0] M_DONE   = 3'd6;
   localparam logic [2:0] M_ERR    = 3'd7;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5c;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_N     = 8'h6e;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_U     = 8'h75;

   logic [2:0]  mode_ff, mode_in, mode_cur;
   logic [1:0]  cnt_ff, cnt_in, cnt_cur;
   logic [15:0] high_ff, high_in, high_cur;
   logic [15:0] acc_ff, acc_in, acc_cur;
   logic [7:0]  b;
   logic [4:0]  hex;
   logic [15:0] unit;
   logic        accept;
   job_type     job;

   // {valid, value}
   function automatic logic [4:0] hexval(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
      else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
         r = {1'b1, c[3:0] + 4'd9};
      return r;
   endfunction

   function automatic job_type one_word(input logic [7:0] v, input logic [1:0] k,
                                        input logic [2:0] e);
      job_type j;
      j = '0;
      j.kind       = k;
      j.error_code = e;
      j.bytes[0]   = v;
      return j;
   endfunction

   function automatic job_type encode(input logic [20:0] cp);
      job_type j;
      j = '0;
      j.kind = KIND_DATA;
      priority if (cp <= 21'h7f) begin
         j.bytes[0] = cp[7:0];
      end else if (cp <= 21'h7ff) begin
         j.last_idx = 2'd1;
         j.bytes[0] = {3'b110, cp[10:6]};
         j.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp <= 21'hffff) begin
         j.last_idx = 2'd2;
         j.bytes[0] = {4'b1110, cp[15:12]};
         j.bytes[1] = {2'b10, cp[11:6]};
         j.bytes[2] = {2'b10, cp[5:0]};
      end else begin
         j.last_idx = 2'd3;
         j.bytes[0] = {5'b11110, cp[20:18]};
         j.bytes[1] = {2'b10, cp[17:12]};
         j.bytes[2] = {2'b10, cp[11:6]};
         j.bytes[3] = {2'b10, cp[5:0]};
      end
      return j;
   endfunction

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && !q_full;
   assign b            = req_ch.payload.in_byte;
   assign hex          = hexval(b);

   always_comb begin
      // restart clears the state before this byte is taken
      mode_cur = req_ch.payload.restart ? M_NORMAL : mode_ff;
      cnt_cur  = req_ch.payload.restart ? 2'd0 : cnt_ff;
      high_cur = req_ch.payload.restart ? 16'd0 : high_ff;
      acc_cur  = req_ch.payload.restart ? 16'd0 : acc_ff;
      mode_in  = mode_cur;
      cnt_in   = cnt_cur;
      high_in  = high_cur;
      acc_in   = acc_cur;
      unit     = {acc_cur[11:0], hex[3:0]};
      push     = 1'b0;
      job      = '0;
      unique case (mode_cur)
         M_NORMAL: begin
            push = 1'b1;
            priority if (b == CH_QUOTE) begin
               mode_in = M_DONE;
               job     = one_word(8'd0, KIND_END, ERR_NONE);
            end else if (b == 8'd0) begin
               mode_in = M_ERR;
               job     = one_word(8'd0, KIND_ERROR, ERR_MISSING_Q);
            end else if (b == CH_BSL) begin
               mode_in = M_ESC;
               push    = 1'b0;
            end else if (b < 8'h20) begin
               mode_in = M_ERR;
               job     = one_word(8'd0, KIND_ERROR, ERR_CTRL_CHAR);
            end else begin
               job = one_word(b, KIND_DATA, ERR_NONE);
            end
         end
         M_ESC: begin
            mode_in = M_NORMAL;
            push    = 1'b1;
            unique case (b)
               CH_QUOTE: job = one_word(CH_QUOTE, KIND_DATA, ERR_NONE);
               CH_BSL:   job = one_word(CH_BSL, KIND_DATA, ERR_NONE);
               CH_SLASH: job = one_word(CH_SLASH, KIND_DATA, ERR_NONE);
               CH_B:     job = one_word(8'h08, KIND_DATA, ERR_NONE);
               CH_F:     job = one_word(8'h0c, KIND_DATA, ERR_NONE);
               CH_N:     job = one_word(8'h0a, KIND_DATA, ERR_NONE);
               CH_T:     job = one_word(8'h09, KIND_DATA, ERR_NONE);
               CH_R:     job = one_word(8'h0d, KIND_DATA, ERR_NONE);
               CH_U: begin
                  mode_in = M_HEX1;
                  cnt_in  = 2'd0;
                  acc_in  = 16'd0;
                  push    = 1'b0;
               end
               default: begin
                  mode_in = M_ERR;
                  job     = one_word(8'd0, KIND_ERROR, ERR_BAD_ESC);
               end
            endcase
         end
         M_HEX1, M_HEX2: begin
            if (!hex[4]) begin
               mode_in = M_ERR;
               push    = 1'b1;
               job     = one_word(8'd0, KIND_ERROR, ERR_BAD_HEX);
            end else if (cnt_cur != 2'd3) begin
               cnt_in = cnt_cur + 2'd1;
               acc_in = unit;
            end else begin
               cnt_in = 2'd0;
               acc_in = 16'd0;
               if (mode_cur == M_HEX1) begin
                  if (unit >= 16'hd800 && unit <= 16'hdbff) begin
                     high_in = unit;
                     mode_in = M_EXP_BS;
                  end else begin
                     mode_in = M_NORMAL;
                     push    = 1'b1;
                     job     = encode({5'd0, unit});
                  end
               end else if (unit < 16'hdc00 || unit > 16'hdfff) begin
                  mode_in = M_ERR;
                  push    = 1'b1;
                  job     = one_word(8'd0, KIND_ERROR, ERR_BAD_SURR);
               end else begin
                  // join the pair: 0x10000 + (hi[9:0] << 10 | lo[9:0])
                  high_in = 16'd0;
                  mode_in = M_NORMAL;
                  push    = 1'b1;
                  job     = encode({1'b0, high_cur[9:0], unit[9:0]} + 21'h10000);
               end
            end
         end
         M_EXP_BS, M_EXP_U: begin
            if (b != ((mode_cur == M_EXP_BS) ? CH_BSL : CH_U)) begin
               mode_in = M_ERR;
               push    = 1'b1;
               job     = one_word(8'd0, KIND_ERROR, ERR_BAD_SURR);
            end else if (mode_cur == M_EXP_BS) begin
               mode_in = M_EXP_U;
            end else begin
               mode_in = M_HEX2;
               cnt_in  = 2'd0;
               acc_in  = 16'd0;
            end
         end
         default: ;  // ended or failed: bytes are dropped
      endcase
      if (mode_in == M_ERR) begin
         cnt_in  = 2'd0;
         acc_in  = 16'd0;
         high_in = 16'd0;
      end
      push = push && accept;
   end

   assign push_job = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_NORMAL;
         cnt_ff  <= 2'd0;
         high_ff <= 16'd0;
         acc_ff  <= 16'd0;
      end else if (accept) begin
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
         high_ff <= high_in;
         acc_ff  <= acc_in;
      end
   end

   // once failed, only a restart leaves the error state
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == M_ERR && !(accept && req_ch.payload.restart)) |=> mode_ff == M_ERR)
      else $error("error state left without restart");

endmodule

@@ sv/jsu_queue.sv @@
// Short job queue between front and back end.
// Depends on jsu_pkg for the job type.
module jsu_queue #(
   parameter int DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jsu_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output jsu_pkg::job_type head_job
);
   import jsu_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   assign full       = (cnt_ff == CNT_W'(DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_job   = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      if (pop)  rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      if (push && !pop) cnt_in = cnt_ff + CNT_W'(1);
      else if (pop && !push) cnt_in = cnt_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_job;
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(push && full) && !(pop && !head_valid))
      else $error("queue pushed when full or popped when empty");

endmodule

@@ sv/jsu_back.sv @@
// Back end: splits each job into result words through an output register.
// Depends on jsu_pkg and jsu_chan_if.
module jsu_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  jsu_pkg::job_type head_job,
   output logic             pop,
   jsu_chan_if.source       rsp_ch
);
   import jsu_pkg::*;

   logic [1:0]      idx_ff, idx_in;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_ff, out_in;
   logic            load, final_word;

   assign load       = head_valid && (!out_valid_ff || rsp_ch.ready);
   assign final_word = (idx_ff == head_job.last_idx);
   assign pop        = load && final_word;

   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (load) begin
         out_valid_in      = 1'b1;
         out_in.out_byte   = head_job.bytes[idx_ff];
         out_in.kind       = head_job.kind;
         out_in.error_code = head_job.error_code;
         out_in.last       = final_word;
         idx_in            = final_word ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.payload = out_ff;

   a_marker_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.payload.kind != KIND_DATA) |-> rsp_ch.payload.last)
      else $error("end or error word not marked last");

   a_code_only_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.payload.kind != KIND_ERROR)
         |-> rsp_ch.payload.error_code == ERR_NONE)
      else $error("error code on a non-error word");

endmodule

@@ sv/json_string_unescape_utf8.sv @@
// Top level of the JSON string unescaper with UTF-8 output.
// Depends on jsu_pkg, jsu_chan_if, jsu_front, jsu_queue and jsu_back.
//
// Usage:
//  - req_ch takes one body byte per word (in_byte) with restart; restart=1
//    starts a new string and clears the decoder before the byte is taken.
//  - rsp_ch returns result words: data bytes (kind 0), an end marker on the
//    closing quote (kind 1) or an error (kind 2, error_code set). last marks
//    the final word caused by one input byte; bytes that cause nothing
//    (backslash, hex digits, dropped bytes after end or error) give no word.
//  - Path: each taken byte's job is written into the queue, then moved to the output register.
//  - Throughput: one input byte per cycle while the queue is not full; the front decodes combinationally.
//    Output is one word per cycle while rsp_ch.ready is high, so a \u escape that
//    yields 2 to 4 UTF-8 bytes holds the output for one word per byte; the job queue
//    (QUEUE_DEPTH entries) soaks up the burst while input keeps flowing.
//  - Stall: when rsp_ch.ready is low the output register holds its word,
//    the queue fills, and req_ch.ready drops once QUEUE_DEPTH jobs wait.
//  - Reset (synchronous, active high): decoder back to plain in-string mode,
//    queue and output register emptied.
module json_string_unescape_utf8 #(
   parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   jsu_chan_if.sink   req_ch,
   jsu_chan_if.source rsp_ch
);
   import jsu_pkg::*;

   // front -> queue
   logic    push, q_full;
   job_type push_job;
   // queue -> back
   logic    pop, head_valid;
   job_type head_job;

   jsu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .q_full   (q_full),
      .push     (push),
      .push_job (push_job)
   );

   jsu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule
